// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the Skein-256 RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/sk256_pkg.sv =====
// Skein-256 package: types, constants and round helpers.
// No dependencies.
`default_nettype none
package sk256_pkg;
  localparam logic [63:0] KsParity = 64'h1BD11BDAA9FC1A22;
  localparam logic [7:0] TypeMsg = 8'd48;
  localparam logic [7:0] TypeOut = 8'd255;

  typedef logic [63:0] word_t;
  typedef word_t [3:0] blk_t;

  // unit command from sequencer to the Threefish core
  typedef struct packed {
    logic  start;
    blk_t  key;
    blk_t  msg;
    word_t t0;
    word_t t1;
  } tf_cmd_t;

  typedef struct packed {
    logic done;
    blk_t cv;
  } tf_rsp_t;

  function automatic blk_t iv_of(input logic [1:0] sz);
    blk_t v;
    case (sz)
      2'd0: v = {64'h6A54E920FDE8DA69, 64'hB33BC3896656840F,
                 64'h2FCA66479FA7D833, 64'hFC9DA860D048B449};
      2'd1: v = {64'h384BDDB1AEDDB5DE, 64'h99CB88D7D7F53884,
                 64'h876D568608C5191C, 64'hC6098A8C9AE5EA0B};
      2'd2: v = {64'h2DD2E4968586AB7D, 64'hD47A58568838D63E,
                 64'h2AC4E9A25A77E590, 64'h1420231472825E98};
      default: v = {64'hCCF7DDE5B45BC1C2, 64'h10080DF491960F7A,
                    64'h883DAAA77C8D811C, 64'hE1111906964D7260};
    endcase
    return v;
  endfunction

  // digest length in bytes
  function automatic logic [5:0] out_len(input logic [1:0] sz);
    logic [5:0] n;
    case (sz)
      2'd0: n = 6'd32;
      2'd1: n = 6'd28;
      2'd2: n = 6'd20;
      default: n = 6'd16;
    endcase
    return n;
  endfunction

  function automatic word_t rotl(input word_t v, input logic [5:0] r);
    return (v << r) | (v >> (7'd64 - {1'b0, r}));
  endfunction

  function automatic logic [5:0] rot0(input logic [2:0] i);
    logic [5:0] r;
    case (i)
      3'd0: r = 6'd14; 3'd1: r = 6'd52; 3'd2: r = 6'd23; 3'd3: r = 6'd5;
      3'd4: r = 6'd25; 3'd5: r = 6'd46; 3'd6: r = 6'd58; default: r = 6'd32;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] rot1(input logic [2:0] i);
    logic [5:0] r;
    case (i)
      3'd0: r = 6'd16; 3'd1: r = 6'd57; 3'd2: r = 6'd40; 3'd3: r = 6'd37;
      3'd4: r = 6'd33; 3'd5: r = 6'd12; 3'd6: r = 6'd22; default: r = 6'd32;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/sk256_if.sv =====
// Valid/ready channel interfaces for the Skein-256 block.
// No dependencies.
`default_nettype none
interface sk256_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  bytes_valid;
  logic        last_item;
  modport source (output valid, data_word, bytes_valid, last_item, input ready);
  modport sink (input valid, data_word, bytes_valid, last_item, output ready);
endinterface

interface sk256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [3:0]  digest_bytes;
  logic        last_word;
  modport source (output valid, digest_word, digest_bytes, last_word, input ready);
  modport sink (input valid, digest_word, digest_bytes, last_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/sk256_tf.sv =====
// Threefish-256 UBI compression, one four-round MIX step per cycle.
// Depends on sk256_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sk256_tf
  import sk256_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  tf_cmd_t cmd,
  output tf_rsp_t rsp
);
  word_t [4:0] k_r;
  word_t [2:0] t_r;
  blk_t        x_r, m_r;
  logic [4:0]  s_r;     // subkey round index 0..18
  logic        odd_r;   // second half of a double round
  logic        busy_r;
  logic        done_r;

  blk_t        mx;
  blk_t        inj;
  logic [2:0]  k0i, k1i, k2i, k3i;
  logic [1:0]  t0i, t1i;
  logic [4:0]  n;

  // operands reach 22 (n + 3 with n up to 19)
  function automatic logic [2:0] mod5(input logic [4:0] v);
    logic [4:0] a;
    a = v;
    if (a >= 5'd20) a = a - 5'd20;
    else if (a >= 5'd15) a = a - 5'd15;
    else if (a >= 5'd10) a = a - 5'd10;
    else if (a >= 5'd5) a = a - 5'd5;
    return a[2:0];
  endfunction

  function automatic logic [1:0] mod3(input logic [4:0] v);
    logic [4:0] a;
    a = v;
    if (a >= 5'd18) a = a - 5'd18;
    if (a >= 5'd9) a = a - 5'd9;
    if (a >= 5'd6) a = a - 5'd6;
    else if (a >= 5'd3) a = a - 5'd3;
    return a[1:0];
  endfunction

  // four MIX/permute rounds
  always_comb begin
    blk_t v;
    logic [2:0] ri;
    v = x_r;
    for (int d = 0; d < 4; d++) begin
      ri = {odd_r, 2'(d)};
      if (d % 2 == 0) begin
        v[0] = v[0] + v[1]; v[1] = rotl(v[1], rot0(ri)) ^ v[0];
        v[2] = v[2] + v[3]; v[3] = rotl(v[3], rot1(ri)) ^ v[2];
      end else begin
        v[0] = v[0] + v[3]; v[3] = rotl(v[3], rot0(ri)) ^ v[0];
        v[2] = v[2] + v[1]; v[1] = rotl(v[1], rot1(ri)) ^ v[2];
      end
    end
    mx = v;
  end

  always_comb begin
    n   = s_r + 5'd1;
    k0i = mod5(n);
    k1i = mod5(n + 5'd1);
    k2i = mod5(n + 5'd2);
    k3i = mod5(n + 5'd3);
    t0i = mod3(n);
    t1i = mod3(n + 5'd1);
    inj[0] = mx[0] + k_r[k0i];
    inj[1] = mx[1] + k_r[k1i] + t_r[t0i];
    inj[2] = mx[2] + k_r[k2i] + t_r[t1i];
    inj[3] = mx[3] + k_r[k3i] + {59'd0, n};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      s_r    <= '0;
      odd_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start && !busy_r) begin
        busy_r <= 1'b1;
        s_r    <= '0;
        odd_r  <= 1'b0;
        k_r    <= {KsParity ^ cmd.key[0] ^ cmd.key[1] ^ cmd.key[2] ^ cmd.key[3], cmd.key};
        t_r    <= {cmd.t0 ^ cmd.t1, cmd.t1, cmd.t0};
        m_r    <= cmd.msg;
        x_r    <= {cmd.msg[3] + cmd.key[3], cmd.msg[2] + cmd.key[2] + cmd.t1,
                   cmd.msg[1] + cmd.key[1] + cmd.t0, cmd.msg[0] + cmd.key[0]};
      end else if (busy_r) begin
        x_r   <= inj;
        odd_r <= ~odd_r;
        s_r   <= n;
        if (s_r == 5'd17) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done_r;
    for (int i = 0; i < 4; i++) rsp.cv[i] = x_r[i] ^ m_r[i];
  end

  `ASSERT_NEXT(a_tf_done_pulse, clk, rst_n, done_r, !done_r)
  `ASSERT_IMPL(a_tf_done_idle, clk, rst_n, done_r, !busy_r)
  `ASSERT_IMPL(a_tf_s_range, clk, rst_n, busy_r, s_r <= 5'd17)
endmodule
`default_nettype wire

// ===== rtl/skein256_hash.sv =====
// Skein-256 hash top level: word buffering, UBI sequencing, digest output.
// Depends on sk256_pkg, sk256_if, sk256_tf and assert_macros.svh.
// A word is accepted in IDLE and its valid bytes are appended one at a time in BYTE,
// which then returns to IDLE; a full buffer met by a new byte is compressed in BLK first.
// A last word then goes to FIN and OUTP, two compressions, and emits 2 to 4 items.
// Sync active-low reset loads the 256-bit IV, clears buffer and position.
`default_nettype none
`include "assert_macros.svh"
module skein256_hash
  import sk256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  sk256_in_if.sink    in_ch,
  sk256_out_if.source out_ch
);
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_BYTE = 6'b000010,  // append bytes one at a time
    ST_BLK  = 6'b000100,  // compress full buffer mid-message
    ST_FIN  = 6'b001000,  // final message block
    ST_OUTP = 6'b010000,  // output pass
    ST_EMIT = 6'b100000
  } st_t;

  st_t         st_r;
  logic [1:0]  size_r;
  blk_t        cv_r, buf_r;
  word_t       pos_r;
  logic        first_r;
  logic [5:0]  fill_r;
  word_t       word_r;
  logic [3:0]  cnt_r;     // bytes left in held word
  logic [2:0]  bi_r;      // byte index in held word
  logic        last_r;
  logic        wait_r;    // compression issued, waiting
  logic [1:0]  oi_r;
  blk_t        dig_r;

  tf_cmd_t     cmd;
  tf_rsp_t     rsp;
  logic [5:0]  olen;
  logic [5:0]  obytes;

  sk256_tf u_tf (.clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp));

  assign olen = out_len(size_r);
  assign obytes = olen - {1'b0, oi_r, 3'd0};

  always_comb begin
    cmd.start = 1'b0;
    cmd.key   = cv_r;
    cmd.msg   = buf_r;
    cmd.t0    = pos_r;
    // message tweak: type in the top byte, first flag in bit 62
    cmd.t1    = {TypeMsg, 56'd0};
    cmd.t1[62] = first_r;
    case (st_r)
      ST_BLK: begin
        cmd.start = !wait_r;
        cmd.t0 = pos_r + 64'd32;
        cmd.t1[63] = 1'b0;
      end
      ST_FIN: begin
        cmd.start = !wait_r;
        cmd.t0 = pos_r + {58'd0, fill_r};
        cmd.t1[63] = 1'b1;
      end
      ST_OUTP: begin
        cmd.start = !wait_r;
        cmd.msg = '0;
        cmd.t0 = 64'd8;
        cmd.t1 = {TypeOut, 56'd0};
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (st_r == ST_IDLE) && !cfg_we;
  assign out_ch.valid = (st_r == ST_EMIT);
  assign out_ch.digest_word = (obytes >= 6'd8) ? dig_r[oi_r] : {32'd0, dig_r[oi_r][31:0]};
  assign out_ch.digest_bytes = (obytes >= 6'd8) ? 4'd8 : obytes[3:0];
  assign out_ch.last_word = (obytes <= 6'd8);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      if (!rst_n) size_r <= 2'd0;
      else size_r <= cfg_wdata;
      cv_r    <= iv_of(rst_n ? cfg_wdata : 2'd0);
      st_r    <= ST_IDLE;
      buf_r   <= '0;
      pos_r   <= '0;
      first_r <= 1'b1;
      fill_r  <= '0;
      wait_r  <= 1'b0;
      oi_r    <= '0;
    end else begin
      case (st_r)
        ST_IDLE: if (in_ch.valid) begin
          word_r <= in_ch.data_word;
          cnt_r  <= (in_ch.bytes_valid > 4'd8) ? 4'd8 : in_ch.bytes_valid;
          bi_r   <= '0;
          last_r <= in_ch.last_item;
          st_r   <= ST_BYTE;
        end
        ST_BYTE: begin
          if (cnt_r == 4'd0) begin
            st_r <= last_r ? ST_FIN : ST_IDLE;
          end else if (fill_r == 6'd32) begin
            st_r <= ST_BLK;
          end else begin
            buf_r[fill_r[4:3]][fill_r[2:0]*8 +: 8] <= word_r[bi_r*8 +: 8];
            fill_r <= fill_r + 6'd1;
            bi_r   <= bi_r + 3'd1;
            cnt_r  <= cnt_r - 4'd1;
          end
        end
        ST_BLK: begin
          wait_r <= 1'b1;
          if (wait_r && rsp.done) begin
            cv_r    <= rsp.cv;
            pos_r   <= pos_r + 64'd32;
            first_r <= 1'b0;
            buf_r   <= '0;
            fill_r  <= '0;
            wait_r  <= 1'b0;
            st_r    <= ST_BYTE;
          end
        end
        ST_FIN: begin
          wait_r <= 1'b1;
          if (wait_r && rsp.done) begin
            cv_r   <= rsp.cv;
            wait_r <= 1'b0;
            st_r   <= ST_OUTP;
          end
        end
        ST_OUTP: begin
          wait_r <= 1'b1;
          if (wait_r && rsp.done) begin
            dig_r   <= rsp.cv;
            wait_r  <= 1'b0;
            oi_r    <= '0;
            cv_r    <= iv_of(size_r);
            pos_r   <= '0;
            first_r <= 1'b1;
            buf_r   <= '0;
            fill_r  <= '0;
            st_r    <= ST_EMIT;
          end
        end
        ST_EMIT: if (out_ch.ready) begin
          if (obytes <= 6'd8) st_r <= ST_IDLE;
          else oi_r <= oi_r + 2'd1;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_fill_range, clk, rst_n, 1'b1, fill_r <= 6'd32)
  `ASSERT_IMPL(a_emit_bytes, clk, rst_n, out_ch.valid,
               out_ch.digest_bytes == 4'd8 || out_ch.digest_bytes == 4'd4)
  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, st_r != ST_IDLE, !in_ch.ready)
endmodule
`default_nettype wire

// ===== verif/skein256_hash_test.sv =====
// Testbench for skein256_hash: drives message words, predicts digests with a
// local Threefish-256 UBI model and checks every digest item in order.
// Depends on sk256_pkg, sk256_if and the skein256_hash RTL.
`default_nettype none
module skein256_hash_test
  import sk256_pkg::*;
();

  typedef struct {
    logic [63:0] dword;
    logic [3:0]  nbytes;
    logic        lastw;
  } digest_item_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  sk256_in_if  in_ch();
  sk256_out_if out_ch();

  skein256_hash dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor state
  logic [1:0]   size_sel;
  blk_t         chain;
  logic [63:0]  msg_pos;
  logic         first_flag;
  blk_t         pend_blk;
  int unsigned  pend_fill;
  digest_item_t digest_q[$];
  int           errors;
  bit           rx_stall_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #80000000;
    $display("skein256_hash_test failed");
    $finish;
  end

  function automatic word_t rol64(word_t v, int r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic blk_t size_iv(logic [1:0] s);
    blk_t v;
    case (s)
      2'd0: v = {64'h6A54E920FDE8DA69, 64'hB33BC3896656840F,
                 64'h2FCA66479FA7D833, 64'hFC9DA860D048B449};
      2'd1: v = {64'h384BDDB1AEDDB5DE, 64'h99CB88D7D7F53884,
                 64'h876D568608C5191C, 64'hC6098A8C9AE5EA0B};
      2'd2: v = {64'h2DD2E4968586AB7D, 64'hD47A58568838D63E,
                 64'h2AC4E9A25A77E590, 64'h1420231472825E98};
      default: v = {64'hCCF7DDE5B45BC1C2, 64'h10080DF491960F7A,
                    64'h883DAAA77C8D811C, 64'hE1111906964D7260};
    endcase
    return v;
  endfunction

  // one UBI compression into chain
  task automatic compress(blk_t m, word_t tw0, word_t tw1);
    word_t k[5];
    word_t tw[3];
    word_t x[4];
    int ra[8];
    int rb[8];
    int a, b, n;
    ra = '{14, 52, 23, 5, 25, 46, 58, 32};
    rb = '{16, 57, 40, 37, 33, 12, 22, 32};
    k[4] = 64'h1BD11BDAA9FC1A22;
    for (int i = 0; i < 4; i++) begin
      k[i] = chain[i];
      k[4] ^= chain[i];
    end
    tw[0] = tw0; tw[1] = tw1; tw[2] = tw0 ^ tw1;
    for (int i = 0; i < 4; i++) x[i] = m[i] + k[i];
    x[1] += tw[0];
    x[2] += tw[1];
    for (int s = 0; s < 18; s++) begin
      for (int d = 0; d < 4; d++) begin
        a = d[0] ? 3 : 1;
        b = d[0] ? 1 : 3;
        x[0] += x[a];
        x[a] = rol64(x[a], ra[(s % 2) * 4 + d]) ^ x[0];
        x[2] += x[b];
        x[b] = rol64(x[b], rb[(s % 2) * 4 + d]) ^ x[2];
      end
      n = s + 1;
      x[0] += k[n % 5];
      x[1] += k[(n + 1) % 5] + tw[n % 3];
      x[2] += k[(n + 2) % 5] + tw[(n + 1) % 3];
      x[3] += k[(n + 3) % 5] + word_t'(n);
    end
    for (int i = 0; i < 4; i++) chain[i] = x[i] ^ m[i];
  endtask

  function automatic word_t msg_tweak(bit fin);
    word_t t;
    t = {TypeMsg, 56'd0};
    t[62] = first_flag;
    t[63] = fin;
    return t;
  endfunction

  task automatic restart_hash();
    chain = size_iv(size_sel);
    msg_pos = '0;
    first_flag = 1'b1;
    pend_blk = '0;
    pend_fill = 0;
  endtask

  // absorb one message word; on the last word queue the digest items
  task automatic absorb_word(logic [63:0] w, logic [3:0] nb, logic lst);
    int cnt, total, nw, left;
    digest_item_t it;
    cnt = (nb > 8) ? 8 : nb;
    for (int i = 0; i < cnt; i++) begin
      if (pend_fill >= 32) begin
        msg_pos += 32;
        compress(pend_blk, msg_pos, msg_tweak(1'b0));
        first_flag = 1'b0;
        pend_blk = '0;
        pend_fill = 0;
      end
      pend_blk[pend_fill / 8][(pend_fill % 8) * 8 +: 8] = w[i * 8 +: 8];
      pend_fill++;
    end
    if (lst) begin
      msg_pos += pend_fill;
      compress(pend_blk, msg_pos, msg_tweak(1'b1));
      compress('0, 64'd8, {TypeOut, 56'd0});
      case (size_sel)
        2'd0: total = 32;
        2'd1: total = 28;
        2'd2: total = 20;
        default: total = 16;
      endcase
      nw = (total + 7) / 8;
      for (int i = 0; i < nw; i++) begin
        left = total - 8 * i;
        it.dword = chain[i];
        it.nbytes = (left >= 8) ? 4'd8 : 4'(left);
        if (left < 8) it.dword[63:32] = '0;
        it.lastw = (i == nw - 1);
        digest_q.push_back(it);
      end
      restart_hash();
    end
  endtask

  // sender: bursts with random gaps; valid drops only in a gap or while draining
  int burst_left;
  task automatic send_word(logic [63:0] w, logic [3:0] nb, logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data_word <= w;
    in_ch.bytes_valid <= nb;
    in_ch.last_item <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_word(w, nb, lst);
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (digest_q.size() != 0) begin
      $display("skein256_hash_test failed");
      $finish;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic set_size(logic [1:0] s);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_sel = s;
    restart_hash();
  endtask

  task automatic send_message(int nwords, bit allow_short);
    logic [3:0] nb;
    for (int i = 0; i < nwords; i++) begin
      nb = 4'd8;
      if (allow_short && $urandom_range(0, 5) == 0) nb = 4'($urandom_range(0, 15));
      if (i == nwords - 1) nb = 4'($urandom_range(0, 8));
      send_word({$urandom, $urandom}, nb, i == nwords - 1);
    end
  endtask

  // receiver: stall pattern, check against oldest expectation
  always @(posedge clk) begin
    digest_item_t exp_item;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest item %h", $time, out_ch.digest_word);
        errors++;
      end else begin
        exp_item = digest_q.pop_front();
        if (out_ch.digest_word !== exp_item.dword) begin
          $display("%0t: digest_word exp %h got %h", $time, exp_item.dword,
                   out_ch.digest_word);
          errors++;
        end
        if (out_ch.digest_bytes !== exp_item.nbytes) begin
          $display("%0t: digest_bytes exp %0d got %0d", $time, exp_item.nbytes,
                   out_ch.digest_bytes);
          errors++;
        end
        if (out_ch.last_word !== exp_item.lastw) begin
          $display("%0t: last_word exp %0d got %0d", $time, exp_item.lastw,
                   out_ch.last_word);
          errors++;
        end
      end
    end
    if ($urandom_range(0, 63) == 0) rx_stall_on <= !rx_stall_on;
    out_ch.ready <= rx_stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  task automatic test_directed();
    send_word('0, 4'd0, 1'b1);                          // empty message
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);    // too many bytes
    send_word(64'hA5A5_A5A5_A5A5_A5A5, 4'd3, 1'b0);     // short word not last
    send_word(64'h0123_4567_89AB_CDEF, 4'd8, 1'b1);
    for (int i = 0; i < 4; i++) send_word(~64'(i), 4'd8, i == 3); // exact block
    for (int i = 0; i < 5; i++) send_word(64'(i), 4'd8, 1'b0);   // block + more
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
  endtask

  task automatic test_sizes();
    for (int s = 3; s >= 0; s--) begin
      set_size(2'(s));
      send_word(64'h8000_0000_0000_0001, 4'd8, 1'b1);
      send_message(6, 1'b1);
    end
  endtask

  task automatic test_abort();
    for (int i = 0; i < 3; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
    set_size(2'd1);                                     // drops partial message
    send_message(2, 1'b0);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 230) begin
      int n;
      if ($urandom_range(0, 9) == 0) set_size(2'($urandom_range(0, 3)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      send_message(n, 1'b1);
      sent += n;
    end
  endtask

  initial begin
    burst_left = 0;
    size_sel = 2'd0;
    restart_hash();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data_word <= '0;
    in_ch.bytes_valid <= '0;
    in_ch.last_item <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_sizes();
    test_abort();
    test_random();
    set_size(2'd0);
    send_message(3, 1'b1);
    wait_drain();
    if (errors == 0) $display("skein256_hash_test passed");
    else $display("skein256_hash_test failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/sk256_pkg.sv
rtl/sk256_if.sv
rtl/sk256_tf.sv
rtl/skein256_hash.sv
verif/skein256_hash_test.sv
